[sv/cpcr_pkg.sv]
package cpcr_pkg;

  // Number format
  localparam int unsigned FracBits     = 16;
  localparam int unsigned CoordW       = 32;
  localparam int unsigned RadiusW      = 31;
  localparam int unsigned DiffW        = CoordW + 1;
  localparam int unsigned SqW          = 2 * DiffW;
  localparam int unsigned RootW        = DiffW;
  localparam int unsigned RemW         = RootW + 2;
  localparam int unsigned RsumW        = RadiusW + 1;

  // Normal and divider
  localparam int unsigned QuotW        = FracBits + 1;
  localparam int unsigned NormW        = FracBits + 2;
  localparam int unsigned DivNumW      = DiffW + FracBits + 1;

  // Response datapath
  localparam int unsigned Sep2W        = RootW + 2;
  localparam int unsigned VrW          = 36;
  localparam int unsigned WideW        = 64;
  localparam int unsigned PushProdW    = Sep2W + NormW;
  localparam int unsigned VanProdW     = DiffW + NormW;
  localparam int unsigned VanW         = VanProdW + 1;

  // Configuration
  localparam int unsigned RestW        = 17;
  localparam int unsigned RestFracBits = 16;
  localparam logic [RestW-1:0] RestOne = RestW'(1) << RestFracBits;
  localparam int unsigned JProdW       = VrW + RestW + 2;
  localparam int unsigned QProdW       = VrW + NormW;
  localparam int unsigned MarginW      = 16;
  localparam logic [MarginW-1:0] MarginReset = MarginW'(66);
  localparam int unsigned CfgIdxW      = 1;
  localparam int unsigned CfgDataW     = 17;

  localparam int unsigned QueueDepth   = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRestitution = 1'b0,
    CfgMargin      = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CoordW-1:0] first_x;
    logic signed [CoordW-1:0] first_y;
    logic signed [CoordW-1:0] second_x;
    logic signed [CoordW-1:0] second_y;
    logic [RadiusW-1:0]       first_radius;
    logic [RadiusW-1:0]       second_radius;
    logic signed [CoordW-1:0] first_vel_x;
    logic signed [CoordW-1:0] first_vel_y;
    logic signed [CoordW-1:0] second_vel_x;
    logic signed [CoordW-1:0] second_vel_y;
  } in_word_t;

  typedef struct packed {
    logic signed [CoordW-1:0] new_first_x;
    logic signed [CoordW-1:0] new_first_y;
    logic signed [CoordW-1:0] new_second_x;
    logic signed [CoordW-1:0] new_second_y;
    logic signed [CoordW-1:0] new_first_vel_x;
    logic signed [CoordW-1:0] new_first_vel_y;
    logic signed [CoordW-1:0] new_second_vel_x;
    logic signed [CoordW-1:0] new_second_vel_y;
    logic                     collided;
    logic                     rebounded;
  } out_word_t;

  // Classified pair handed from front to back
  typedef struct packed {
    in_word_t          word;
    logic [DiffW-1:0]  ax;
    logic [DiffW-1:0]  ay;
    logic              neg_x;
    logic              neg_y;
    logic [RootW-1:0]  dlen;
    logic              collided;
    logic [RootW-1:0]  overlap;
  } pair_info_t;

endpackage

[sv/cpcr_front.sv]
module cpcr_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  cpcr_pkg::in_word_t    in_word_i,
  output logic                  info_valid_o,
  input  logic                  info_stall_i,
  output cpcr_pkg::pair_info_t  info_o
);

  localparam int unsigned NumStages = 3 + cpcr_pkg::RootW;
  localparam int unsigned CW        = cpcr_pkg::CoordW;

  typedef struct packed {
    cpcr_pkg::in_word_t                word;
    logic [cpcr_pkg::RsumW-1:0]        rsum;
    logic                              neg_x;
    logic                              neg_y;
    logic [cpcr_pkg::DiffW-1:0]        ax;
    logic [cpcr_pkg::DiffW-1:0]        ay;
    logic [cpcr_pkg::SqW-1:0]          sx;
    logic [cpcr_pkg::SqW-1:0]          sy;
    logic [cpcr_pkg::SqW-1:0]          rad;
    logic [cpcr_pkg::RemW-1:0]         rem;
    logic [cpcr_pkg::RootW-1:0]        root;
  } fctx_t;

  fctx_t                st_d [NumStages];
  fctx_t                st_q [NumStages];
  logic [NumStages-1:0] vld_q;
  logic                 adv;
  fctx_t                last;

  assign adv        = !(vld_q[NumStages-1] && info_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStages-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NumStages; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // differences and magnitudes
  always_comb begin
    logic signed [cpcr_pkg::DiffW-1:0] dx;
    logic signed [cpcr_pkg::DiffW-1:0] dy;
    dx = {in_word_i.second_x[CW-1], in_word_i.second_x}
       - {in_word_i.first_x[CW-1], in_word_i.first_x};
    dy = {in_word_i.second_y[CW-1], in_word_i.second_y}
       - {in_word_i.first_y[CW-1], in_word_i.first_y};
    st_d[0]       = '0;
    st_d[0].word  = in_word_i;
    st_d[0].neg_x = dx[cpcr_pkg::DiffW-1];
    st_d[0].neg_y = dy[cpcr_pkg::DiffW-1];
    st_d[0].ax    = dx[cpcr_pkg::DiffW-1] ? cpcr_pkg::DiffW'(-dx) : cpcr_pkg::DiffW'(dx);
    st_d[0].ay    = dy[cpcr_pkg::DiffW-1] ? cpcr_pkg::DiffW'(-dy) : cpcr_pkg::DiffW'(dy);
    st_d[0].rsum  = cpcr_pkg::RsumW'(in_word_i.first_radius)
                  + cpcr_pkg::RsumW'(in_word_i.second_radius);
  end

  // squares
  always_comb begin
    st_d[1]    = st_q[0];
    st_d[1].sx = st_q[0].ax * st_q[0].ax;
    st_d[1].sy = st_q[0].ay * st_q[0].ay;
  end

  // radicand
  always_comb begin
    st_d[2]      = st_q[1];
    st_d[2].rad  = st_q[1].sx + st_q[1].sy;
    st_d[2].rem  = '0;
    st_d[2].root = '0;
  end

  // restoring square root, one root bit per stage
  for (genvar j = 0; j < cpcr_pkg::RootW; j++) begin : g_sqrt
    always_comb begin
      logic [cpcr_pkg::RemW+1:0] rem_n;
      logic [cpcr_pkg::RemW+1:0] trial;
      logic                      ge;
      rem_n = {st_q[j+2].rem, st_q[j+2].rad[cpcr_pkg::SqW-1 -: 2]};
      trial = (cpcr_pkg::RemW+2)'({st_q[j+2].root, 2'b01});
      ge    = (rem_n >= trial);
      st_d[j+3]      = st_q[j+2];
      st_d[j+3].rem  = ge ? cpcr_pkg::RemW'(rem_n - trial) : cpcr_pkg::RemW'(rem_n);
      st_d[j+3].root = {st_q[j+2].root[cpcr_pkg::RootW-2:0], ge};
      st_d[j+3].rad  = st_q[j+2].rad << 2;
    end
  end

  assign last         = st_q[NumStages-1];
  assign info_valid_o = vld_q[NumStages-1];

  always_comb begin
    info_o          = '0;
    info_o.word     = last.word;
    info_o.ax       = last.ax;
    info_o.ay       = last.ay;
    info_o.neg_x    = last.neg_x;
    info_o.neg_y    = last.neg_y;
    info_o.dlen     = last.root;
    info_o.collided = (cpcr_pkg::RootW'(last.rsum) > last.root);
    info_o.overlap  = cpcr_pkg::RootW'(last.rsum) - last.root;
  end

endmodule

[sv/cpcr_queue.sv]
module cpcr_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_valid_i,
  output logic                  wr_stall_o,
  input  cpcr_pkg::pair_info_t  wr_data_i,
  output logic                  rd_valid_o,
  input  logic                  rd_stall_i,
  output cpcr_pkg::pair_info_t  rd_data_o
);

  localparam int unsigned Depth = cpcr_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  cpcr_pkg::pair_info_t mem_q [Depth];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 push, pop;

  assign wr_stall_o = (cnt_q == CntW'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign push       = wr_valid_i && !wr_stall_o;
  assign pop        = rd_valid_o && !rd_stall_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

[sv/cpcr_back.sv]
module cpcr_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              info_valid_i,
  output logic                              info_stall_o,
  input  cpcr_pkg::pair_info_t              info_i,
  input  logic [cpcr_pkg::RestW-1:0]        restitution_i,
  input  logic [cpcr_pkg::MarginW-1:0]      margin_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output cpcr_pkg::out_word_t               out_word_o
);

  localparam int unsigned QW        = cpcr_pkg::QuotW;
  localparam int unsigned NumStages = QW + 10;
  localparam int unsigned StNorm    = QW + 1;
  localparam int unsigned StMul     = QW + 2;
  localparam int unsigned StRnd     = QW + 3;
  localparam int unsigned StPos     = QW + 4;
  localparam int unsigned StJmul    = QW + 5;
  localparam int unsigned StJrnd    = QW + 6;
  localparam int unsigned StQmul    = QW + 7;
  localparam int unsigned StQrnd    = QW + 8;
  localparam int unsigned StFin     = QW + 9;
  localparam int unsigned CW        = cpcr_pkg::CoordW;
  localparam int unsigned WW        = cpcr_pkg::WideW;

  typedef struct packed {
    cpcr_pkg::in_word_t                        word;
    cpcr_pkg::out_word_t                       res;
    logic                                      collided;
    logic                                      rebound;
    logic                                      zero_dist;
    logic                                      neg_x;
    logic                                      neg_y;
    logic [cpcr_pkg::RootW-1:0]                dlen;
    logic [cpcr_pkg::DivNumW-1:0]              remx;
    logic [cpcr_pkg::DivNumW-1:0]              remy;
    logic [QW-1:0]                             qx;
    logic [QW-1:0]                             qy;
    logic signed [cpcr_pkg::Sep2W-1:0]         sep2;
    logic signed [cpcr_pkg::DiffW-1:0]         dvx;
    logic signed [cpcr_pkg::DiffW-1:0]         dvy;
    logic signed [cpcr_pkg::NormW-1:0]         nx;
    logic signed [cpcr_pkg::NormW-1:0]         ny;
    logic signed [cpcr_pkg::PushProdW-1:0]     ppx;
    logic signed [cpcr_pkg::PushProdW-1:0]     ppy;
    logic signed [cpcr_pkg::VanProdW-1:0]      pvx;
    logic signed [cpcr_pkg::VanProdW-1:0]      pvy;
    logic signed [cpcr_pkg::PushProdW-1:0]     px;
    logic signed [cpcr_pkg::PushProdW-1:0]     py;
    logic signed [cpcr_pkg::VanW-1:0]          van;
    logic signed [cpcr_pkg::VrW-1:0]           vr;
    logic signed [cpcr_pkg::JProdW-1:0]        jp;
    logic signed [cpcr_pkg::VrW-1:0]           jv;
    logic signed [cpcr_pkg::QProdW-1:0]        qpx;
    logic signed [cpcr_pkg::QProdW-1:0]        qpy;
    logic signed [cpcr_pkg::VrW-1:0]           dqx;
    logic signed [cpcr_pkg::VrW-1:0]           dqy;
  } bctx_t;

  // v / 2^sh, rounded half away from zero
  function automatic logic signed [cpcr_pkg::WideW-1:0] shr_round(
    input logic signed [cpcr_pkg::WideW-1:0] v,
    input int unsigned                       sh
  );
    logic [cpcr_pkg::WideW-1:0] m;
    m = v[cpcr_pkg::WideW-1] ? cpcr_pkg::WideW'(-v) : cpcr_pkg::WideW'(v);
    m = (m + (cpcr_pkg::WideW'(1) << (sh - 1))) >> sh;
    return v[cpcr_pkg::WideW-1] ? signed'(-m) : signed'(m);
  endfunction

  function automatic logic signed [cpcr_pkg::CoordW-1:0] sat_coord(
    input logic signed [cpcr_pkg::WideW-1:0] v
  );
    logic fits;
    fits = (&v[cpcr_pkg::WideW-1:cpcr_pkg::CoordW-1]) ||
           !(|v[cpcr_pkg::WideW-1:cpcr_pkg::CoordW-1]);
    if (fits) begin
      return v[cpcr_pkg::CoordW-1:0];
    end else if (v[cpcr_pkg::WideW-1]) begin
      return {1'b1, {(cpcr_pkg::CoordW-1){1'b0}}};
    end else begin
      return {1'b0, {(cpcr_pkg::CoordW-1){1'b1}}};
    end
  endfunction

  bctx_t                ctx_d [NumStages];
  bctx_t                ctx_q [NumStages];
  logic [NumStages-1:0] vld_q;
  logic                 adv;
  logic signed [cpcr_pkg::RestW+1:0] rest_fac;

  assign adv          = !(vld_q[NumStages-1] && out_stall_i);
  assign info_stall_o = !adv;
  assign out_valid_o  = vld_q[NumStages-1];
  assign out_word_o   = ctx_q[StFin].res;

  // (1 + e) in signed Q2.16
  assign rest_fac = signed'({1'b0, (cpcr_pkg::RestW+1)'(cpcr_pkg::RestOne)
                                 + (cpcr_pkg::RestW+1)'(restitution_i)});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStages-2:0], info_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NumStages; k++) begin
        ctx_q[k] <= ctx_d[k];
      end
    end
  end

  // dividend setup, push distance, relative velocity
  always_comb begin
    ctx_d[0]           = '0;
    ctx_d[0].word      = info_i.word;
    ctx_d[0].collided  = info_i.collided;
    ctx_d[0].zero_dist = (info_i.dlen == '0);
    ctx_d[0].neg_x     = info_i.neg_x;
    ctx_d[0].neg_y     = info_i.neg_y;
    ctx_d[0].dlen      = info_i.dlen;
    ctx_d[0].remx      = (cpcr_pkg::DivNumW'(info_i.ax) << cpcr_pkg::FracBits)
                       + cpcr_pkg::DivNumW'(info_i.dlen >> 1);
    ctx_d[0].remy      = (cpcr_pkg::DivNumW'(info_i.ay) << cpcr_pkg::FracBits)
                       + cpcr_pkg::DivNumW'(info_i.dlen >> 1);
    ctx_d[0].sep2      = cpcr_pkg::Sep2W'(info_i.overlap)
                       + (cpcr_pkg::Sep2W'(margin_i) << 1);
    ctx_d[0].dvx       = {info_i.word.first_vel_x[CW-1], info_i.word.first_vel_x}
                       - {info_i.word.second_vel_x[CW-1], info_i.word.second_vel_x};
    ctx_d[0].dvy       = {info_i.word.first_vel_y[CW-1], info_i.word.first_vel_y}
                       - {info_i.word.second_vel_y[CW-1], info_i.word.second_vel_y};
  end

  // restoring division, one quotient bit per stage; quotient never exceeds 2^F
  for (genvar j = 0; j < QW; j++) begin : g_div
    always_comb begin
      logic [cpcr_pkg::DivNumW-1:0] dd;
      logic                         gex, gey;
      dd  = cpcr_pkg::DivNumW'(ctx_q[j].dlen) << (QW - 1 - j);
      gex = (ctx_q[j].remx >= dd);
      gey = (ctx_q[j].remy >= dd);
      ctx_d[j+1]      = ctx_q[j];
      ctx_d[j+1].remx = gex ? ctx_q[j].remx - dd : ctx_q[j].remx;
      ctx_d[j+1].remy = gey ? ctx_q[j].remy - dd : ctx_q[j].remy;
      ctx_d[j+1].qx   = {ctx_q[j].qx[QW-2:0], gex};
      ctx_d[j+1].qy   = {ctx_q[j].qy[QW-2:0], gey};
    end
  end

  // signed unit normal; coincident centres take (1, 0)
  always_comb begin
    logic signed [cpcr_pkg::NormW-1:0] qxs, qys;
    qxs = signed'({1'b0, ctx_q[StNorm-1].qx});
    qys = signed'({1'b0, ctx_q[StNorm-1].qy});
    ctx_d[StNorm] = ctx_q[StNorm-1];
    if (ctx_q[StNorm-1].zero_dist) begin
      ctx_d[StNorm].nx = cpcr_pkg::NormW'(1) << cpcr_pkg::FracBits;
      ctx_d[StNorm].ny = '0;
    end else begin
      ctx_d[StNorm].nx = ctx_q[StNorm-1].neg_x ? -qxs : qxs;
      ctx_d[StNorm].ny = ctx_q[StNorm-1].neg_y ? -qys : qys;
    end
  end

  always_comb begin
    ctx_d[StMul]     = ctx_q[StMul-1];
    ctx_d[StMul].ppx = ctx_q[StMul-1].sep2 * ctx_q[StMul-1].nx;
    ctx_d[StMul].ppy = ctx_q[StMul-1].sep2 * ctx_q[StMul-1].ny;
    ctx_d[StMul].pvx = ctx_q[StMul-1].dvx * ctx_q[StMul-1].nx;
    ctx_d[StMul].pvy = ctx_q[StMul-1].dvy * ctx_q[StMul-1].ny;
  end

  always_comb begin
    ctx_d[StRnd]     = ctx_q[StRnd-1];
    ctx_d[StRnd].px  = cpcr_pkg::PushProdW'(shr_round(WW'(ctx_q[StRnd-1].ppx),
                                                      cpcr_pkg::FracBits + 1));
    ctx_d[StRnd].py  = cpcr_pkg::PushProdW'(shr_round(WW'(ctx_q[StRnd-1].ppy),
                                                      cpcr_pkg::FracBits + 1));
    ctx_d[StRnd].van = cpcr_pkg::VanW'(ctx_q[StRnd-1].pvx)
                     + cpcr_pkg::VanW'(ctx_q[StRnd-1].pvy);
  end

  // separated positions, rounded normal speed
  always_comb begin
    bctx_t p;
    p = ctx_q[StPos-1];
    ctx_d[StPos] = p;
    ctx_d[StPos].res.new_first_x  = p.word.first_x;
    ctx_d[StPos].res.new_first_y  = p.word.first_y;
    ctx_d[StPos].res.new_second_x = p.word.second_x;
    ctx_d[StPos].res.new_second_y = p.word.second_y;
    if (p.collided) begin
      ctx_d[StPos].res.new_first_x  = sat_coord(WW'(p.word.first_x) - WW'(p.px));
      ctx_d[StPos].res.new_first_y  = sat_coord(WW'(p.word.first_y) - WW'(p.py));
      ctx_d[StPos].res.new_second_x = sat_coord(WW'(p.word.second_x) + WW'(p.px));
      ctx_d[StPos].res.new_second_y = sat_coord(WW'(p.word.second_y) + WW'(p.py));
    end
    ctx_d[StPos].vr      = cpcr_pkg::VrW'(shr_round(WW'(p.van), cpcr_pkg::FracBits));
    ctx_d[StPos].rebound = p.collided && !p.van[cpcr_pkg::VanW-1];
  end

  always_comb begin
    ctx_d[StJmul]    = ctx_q[StJmul-1];
    ctx_d[StJmul].jp = ctx_q[StJmul-1].vr * rest_fac;
  end

  always_comb begin
    ctx_d[StJrnd]    = ctx_q[StJrnd-1];
    ctx_d[StJrnd].jv = cpcr_pkg::VrW'(shr_round(WW'(ctx_q[StJrnd-1].jp),
                                                cpcr_pkg::RestFracBits + 1));
  end

  always_comb begin
    ctx_d[StQmul]     = ctx_q[StQmul-1];
    ctx_d[StQmul].qpx = ctx_q[StQmul-1].jv * ctx_q[StQmul-1].nx;
    ctx_d[StQmul].qpy = ctx_q[StQmul-1].jv * ctx_q[StQmul-1].ny;
  end

  always_comb begin
    ctx_d[StQrnd]     = ctx_q[StQrnd-1];
    ctx_d[StQrnd].dqx = cpcr_pkg::VrW'(shr_round(WW'(ctx_q[StQrnd-1].qpx),
                                                 cpcr_pkg::FracBits));
    ctx_d[StQrnd].dqy = cpcr_pkg::VrW'(shr_round(WW'(ctx_q[StQrnd-1].qpy),
                                                 cpcr_pkg::FracBits));
  end

  // impulse applied, flags; this stage is the output register
  always_comb begin
    bctx_t p;
    p = ctx_q[StFin-1];
    ctx_d[StFin] = p;
    ctx_d[StFin].res.new_first_vel_x  = p.word.first_vel_x;
    ctx_d[StFin].res.new_first_vel_y  = p.word.first_vel_y;
    ctx_d[StFin].res.new_second_vel_x = p.word.second_vel_x;
    ctx_d[StFin].res.new_second_vel_y = p.word.second_vel_y;
    if (p.rebound) begin
      ctx_d[StFin].res.new_first_vel_x  = sat_coord(WW'(p.word.first_vel_x) - WW'(p.dqx));
      ctx_d[StFin].res.new_first_vel_y  = sat_coord(WW'(p.word.first_vel_y) - WW'(p.dqy));
      ctx_d[StFin].res.new_second_vel_x = sat_coord(WW'(p.word.second_vel_x) + WW'(p.dqx));
      ctx_d[StFin].res.new_second_vel_y = sat_coord(WW'(p.word.second_vel_y) + WW'(p.dqy));
    end
    ctx_d[StFin].res.collided  = p.collided;
    ctx_d[StFin].res.rebounded = p.rebound;
  end

endmodule

[sv/circle_pair_collision_response.sv]
// Equal-mass collision response with configurable restitution for one pair of circles per word.
//
// Input channel (in_valid_i / in_stall_o / in_word_i): a word is taken at a
// rising edge with in_valid_i high and in_stall_o low. Output channel
// (out_valid_o / out_stall_i / out_word_o): one result word per input word,
// in order; it holds steady while out_stall_i is high.
// Config port: cfg_we_i writes cfg_data_i into register cfg_index_i
// (restitution, separation margin). Write only while the block is drained.
//
// Throughput: one word per clock while no stall holds the flow. A word passes
// from the accepting edge to out_valid_o through the front end (difference,
// squares, radicand, 33-step square root pipe), the two-entry queue and the
// back end (17-step normal divider, then the push and impulse multiply/round
// stages; its last stage is the output register).
// A stall at the output freezes the back end; the queue absorbs the front
// end until full, and only then does in_stall_o rise.
// Reset clears all valids and the queue; restitution returns to 1.0 and the
// margin to 66 (about 0.001).
module circle_pair_collision_response (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  cpcr_pkg::in_word_t             in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output cpcr_pkg::out_word_t            out_word_o,
  input  logic                           cfg_we_i,
  input  logic [cpcr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cpcr_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic [cpcr_pkg::RestW-1:0]   rest_q;
  logic [cpcr_pkg::MarginW-1:0] margin_q;

  // front end -> queue
  logic                 fr_valid, fr_stall;
  cpcr_pkg::pair_info_t fr_info;
  // queue -> back end
  logic                 bk_valid, bk_stall;
  cpcr_pkg::pair_info_t bk_info;

  // Config registers; restitution clamps at 1.0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q   <= cpcr_pkg::RestOne;
      margin_q <= cpcr_pkg::MarginReset;
    end else if (cfg_we_i) begin
      case (cpcr_pkg::cfg_reg_e'(cfg_index_i))
        cpcr_pkg::CfgRestitution: begin
          rest_q <= (cfg_data_i > cpcr_pkg::CfgDataW'(cpcr_pkg::RestOne)) ?
                    cpcr_pkg::RestOne : cfg_data_i[cpcr_pkg::RestW-1:0];
        end
        cpcr_pkg::CfgMargin: begin
          margin_q <= cfg_data_i[cpcr_pkg::MarginW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Distance and overlap classification
  cpcr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_word_i    (in_word_i),
    .info_valid_o (fr_valid),
    .info_stall_i (fr_stall),
    .info_o       (fr_info)
  );

  // Decouples the two pipes so each stalls on its own
  cpcr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_stall_o (fr_stall),
    .wr_data_i  (fr_info),
    .rd_valid_o (bk_valid),
    .rd_stall_i (bk_stall),
    .rd_data_o  (bk_info)
  );

  // Normal, separation and impulse
  cpcr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .info_valid_i  (bk_valid),
    .info_stall_o  (bk_stall),
    .info_i        (bk_info),
    .restitution_i (rest_q),
    .margin_i      (margin_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_word_o    (out_word_o)
  );

endmodule

[sv/cpcr_checker.sv]
module cpcr_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input cpcr_pkg::out_word_t            out_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_word_o))
    else $error("output word changed while stalled");

  a_rebound_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.rebounded |-> out_word_o.collided)
    else $error("impulse applied without overlap");

  a_empty_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind circle_pair_collision_response cpcr_checker u_checker (.*);
